// ----- rtl/rmvs_pkg.sv -----
package rmvs_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COUNT_BITS     = 16;
    localparam int MEAN_FRAC_BITS = 16;

    // Mean and sample difference in Q.MEAN_FRAC_BITS.
    localparam int MEAN_W   = SAMPLE_BITS + MEAN_FRAC_BITS;
    localparam int TOTAL_W  = 40;
    localparam int M2_W     = 64;
    localparam int M2_FRAC  = 8;
    localparam int VAR_W    = 54;
    localparam int SD_W     = 27;

    // The shared adder works on the widest operand, which is M2.
    localparam int ALU_W    = M2_W;
    localparam int PROD_W   = 2 * MEAN_W;
    localparam int M2_SHIFT = 2 * MEAN_FRAC_BITS - M2_FRAC;
    localparam int REM_W    = COUNT_BITS;
    localparam int ITER_W   = $clog2(ALU_W + 1);

    localparam int VAR_MIN_COUNT = 2;

    localparam int RES_BITS = COUNT_BITS + MEAN_W + VAR_W + SD_W + 2 * SAMPLE_BITS
                              + TOTAL_W + 1;
    localparam int M_TDATA_W = ((RES_BITS + 7) / 8) * 8;
    localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic                   clear;
        logic [SAMPLE_BITS-1:0] sample;
    } stats_req_t;

    typedef struct packed {
        logic                   overflow;
        logic [TOTAL_W-1:0]     total_us;
        logic [SAMPLE_BITS-1:0] max_us;
        logic [SAMPLE_BITS-1:0] min_us;
        logic [SD_W-1:0]        std_dev_q4;
        logic [VAR_W-1:0]       variance_q8;
        logic [MEAN_W-1:0]      mean_q16;
        logic [COUNT_BITS-1:0]  sample_count;
    } stats_result_t;

endpackage

// ----- rtl/rmvs_alu.sv -----
module rmvs_alu (
    input  rmvs_pkg::alu_req_t         req,
    output logic [rmvs_pkg::ALU_W:0]   y
);

    logic [rmvs_pkg::ALU_W-1:0] b_op;

    // On subtract the top bit is the carry, which is set when a >= b.
    assign b_op = req.sub ? ~req.b : req.b;
    assign y    = {1'b0, req.a} + {1'b0, b_op}
                  + {{rmvs_pkg::ALU_W{1'b0}}, req.sub};

endmodule

// ----- rtl/rmvs_engine.sv -----
module rmvs_engine (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  rmvs_pkg::stats_req_t    req,
    output logic                    in_ready,
    output logic                    res_valid,
    input  logic                    res_take,
    output rmvs_pkg::stats_result_t res
);

    typedef enum logic [13:0] {
        ST_IDLE       = 14'b00000000000001,
        ST_DELTA_SIGN = 14'b00000000000010,
        ST_DELTA_MAG  = 14'b00000000000100,
        ST_STEP_DIV   = 14'b00000000001000,
        ST_MEAN       = 14'b00000000010000,
        ST_D2         = 14'b00000000100000,
        ST_MUL        = 14'b00000001000000,
        ST_M2         = 14'b00000010000000,
        ST_COMMIT     = 14'b00000100000000,
        ST_VAR_INIT   = 14'b00001000000000,
        ST_VAR_DIV    = 14'b00010000000000,
        ST_SQRT_INIT  = 14'b00100000000000,
        ST_SQRT       = 14'b01000000000000,
        ST_DONE       = 14'b10000000000000
    } state_t;

    localparam logic [rmvs_pkg::ITER_W-1:0] STEP_ITERS =
        rmvs_pkg::ITER_W'(rmvs_pkg::MEAN_W);
    localparam logic [rmvs_pkg::ITER_W-1:0] MUL_ITERS =
        rmvs_pkg::ITER_W'(rmvs_pkg::MEAN_W);
    localparam logic [rmvs_pkg::ITER_W-1:0] VAR_ITERS =
        rmvs_pkg::ITER_W'(rmvs_pkg::ALU_W);
    localparam logic [rmvs_pkg::ITER_W-1:0] SQRT_ITERS =
        rmvs_pkg::ITER_W'(rmvs_pkg::ALU_W / 2);
    localparam logic [rmvs_pkg::ITER_W-1:0] ITER_LAST = rmvs_pkg::ITER_W'(1);
    localparam logic [rmvs_pkg::ALU_W-1:0] SQRT_BIT0 =
        rmvs_pkg::ALU_W'(1) << (rmvs_pkg::ALU_W - 2);
    localparam logic [rmvs_pkg::COUNT_BITS-1:0] COUNT_MAX =
        {rmvs_pkg::COUNT_BITS{1'b1}};
    localparam logic [rmvs_pkg::COUNT_BITS-1:0] COUNT_ONE =
        rmvs_pkg::COUNT_BITS'(1);
    localparam logic [rmvs_pkg::COUNT_BITS-1:0] COUNT_VAR_MIN =
        rmvs_pkg::COUNT_BITS'(rmvs_pkg::VAR_MIN_COUNT);

    state_t state_reg, state_next;

    logic [rmvs_pkg::COUNT_BITS-1:0]  count_reg, count_next;
    logic [rmvs_pkg::MEAN_W-1:0]      mean_reg, mean_next;
    logic [rmvs_pkg::M2_W-1:0]        m2_reg, m2_next;
    logic [rmvs_pkg::SAMPLE_BITS-1:0] min_reg, min_next;
    logic [rmvs_pkg::SAMPLE_BITS-1:0] max_reg, max_next;
    logic [rmvs_pkg::TOTAL_W-1:0]     total_reg, total_next;

    logic [rmvs_pkg::SAMPLE_BITS-1:0] x_reg, x_next;
    logic                             ovf_reg, ovf_next;
    logic                             neg_reg, neg_next;
    logic [rmvs_pkg::COUNT_BITS-1:0]  n_reg, n_next;
    logic [rmvs_pkg::MEAN_W-1:0]      dmag_reg, dmag_next;
    logic [rmvs_pkg::MEAN_W-1:0]      nmean_reg, nmean_next;
    logic [rmvs_pkg::ALU_W-1:0]       acc_reg, acc_next;
    logic [rmvs_pkg::REM_W-1:0]       rem_reg, rem_next;
    logic [rmvs_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic [rmvs_pkg::ALU_W-1:0]       var_reg, var_next;
    logic [rmvs_pkg::ALU_W-1:0]       root_reg, root_next;
    logic [rmvs_pkg::ALU_W-1:0]       bit_reg, bit_next;
    logic [rmvs_pkg::ITER_W-1:0]      iter_reg, iter_next;

    rmvs_pkg::alu_req_t           alu_req;
    logic [rmvs_pkg::ALU_W:0]     alu_y;
    logic                         alu_carry;
    logic [rmvs_pkg::MEAN_W-1:0]  xq;
    logic [rmvs_pkg::REM_W:0]     trial;
    logic [rmvs_pkg::REM_W-1:0]   den;

    rmvs_alu u_alu (
        .req (alu_req),
        .y   (alu_y)
    );

    assign alu_carry = alu_y[rmvs_pkg::ALU_W];
    assign xq        = {x_reg, {rmvs_pkg::MEAN_FRAC_BITS{1'b0}}};
    assign trial     = {rem_reg, acc_reg[rmvs_pkg::ALU_W-1]};
    assign den       = (state_reg == ST_VAR_DIV) ? count_reg : n_reg;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        mean_next  = mean_reg;
        m2_next    = m2_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        total_next = total_reg;
        x_next     = x_reg;
        ovf_next   = ovf_reg;
        neg_next   = neg_reg;
        n_next     = n_reg;
        dmag_next  = dmag_reg;
        nmean_next = nmean_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        prod_next  = prod_reg;
        var_next   = var_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        iter_next  = iter_reg;
        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.sub = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    x_next = req.sample;
                    if (req.clear) begin
                        count_next = '0;
                        mean_next  = '0;
                        m2_next    = '0;
                        min_next   = '0;
                        max_next   = '0;
                        total_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_VAR_INIT;
                    end else if (count_reg == COUNT_MAX) begin
                        ovf_next   = 1'b1;
                        state_next = ST_VAR_INIT;
                    end else begin
                        ovf_next   = 1'b0;
                        n_next     = count_reg + COUNT_ONE;
                        state_next = ST_DELTA_SIGN;
                    end
                end
            end
            ST_DELTA_SIGN: begin
                alu_req.a   = rmvs_pkg::ALU_W'(xq);
                alu_req.b   = rmvs_pkg::ALU_W'(mean_reg);
                alu_req.sub = 1'b1;
                neg_next    = !alu_carry;
                state_next  = ST_DELTA_MAG;
            end
            ST_DELTA_MAG: begin
                alu_req.a   = rmvs_pkg::ALU_W'(neg_reg ? mean_reg : xq);
                alu_req.b   = rmvs_pkg::ALU_W'(neg_reg ? xq : mean_reg);
                alu_req.sub = 1'b1;
                dmag_next   = alu_y[rmvs_pkg::MEAN_W-1:0];
                // Dividend sits in the top bits so the quotient lands in the low bits.
                acc_next    = {alu_y[rmvs_pkg::MEAN_W-1:0],
                               {(rmvs_pkg::ALU_W - rmvs_pkg::MEAN_W){1'b0}}};
                rem_next    = '0;
                iter_next   = STEP_ITERS;
                state_next  = ST_STEP_DIV;
            end
            ST_STEP_DIV, ST_VAR_DIV: begin
                alu_req.a   = rmvs_pkg::ALU_W'(trial);
                alu_req.b   = rmvs_pkg::ALU_W'(den);
                alu_req.sub = 1'b1;
                rem_next    = alu_carry ? alu_y[rmvs_pkg::REM_W-1:0]
                                        : trial[rmvs_pkg::REM_W-1:0];
                acc_next    = {acc_reg[rmvs_pkg::ALU_W-2:0], alu_carry};
                iter_next   = iter_reg - ITER_LAST;
                if (iter_reg == ITER_LAST) begin
                    state_next = (state_reg == ST_STEP_DIV) ? ST_MEAN : ST_SQRT_INIT;
                end
            end
            ST_MEAN: begin
                alu_req.a   = rmvs_pkg::ALU_W'(mean_reg);
                alu_req.b   = rmvs_pkg::ALU_W'(acc_reg[rmvs_pkg::MEAN_W-1:0]);
                alu_req.sub = neg_reg;
                nmean_next  = alu_y[rmvs_pkg::MEAN_W-1:0];
                state_next  = ST_D2;
            end
            ST_D2: begin
                alu_req.a   = rmvs_pkg::ALU_W'(neg_reg ? nmean_reg : xq);
                alu_req.b   = rmvs_pkg::ALU_W'(neg_reg ? xq : nmean_reg);
                alu_req.sub = 1'b1;
                prod_next   = {{rmvs_pkg::MEAN_W{1'b0}}, alu_y[rmvs_pkg::MEAN_W-1:0]};
                iter_next   = MUL_ITERS;
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                alu_req.a = rmvs_pkg::ALU_W'(prod_reg[rmvs_pkg::PROD_W-1:rmvs_pkg::MEAN_W]);
                alu_req.b = rmvs_pkg::ALU_W'(dmag_reg);
                if (prod_reg[0]) begin
                    prod_next = {alu_y[rmvs_pkg::MEAN_W:0],
                                 prod_reg[rmvs_pkg::MEAN_W-1:1]};
                end else begin
                    prod_next = {1'b0, prod_reg[rmvs_pkg::PROD_W-1:1]};
                end
                iter_next = iter_reg - ITER_LAST;
                if (iter_reg == ITER_LAST) begin
                    state_next = ST_M2;
                end
            end
            ST_M2: begin
                alu_req.a = m2_reg;
                alu_req.b = rmvs_pkg::ALU_W'(prod_reg[rmvs_pkg::PROD_W-1:rmvs_pkg::M2_SHIFT]);
                // A carry out of M2 rejects the sample and leaves all statistics as they were.
                if (alu_carry) begin
                    ovf_next   = 1'b1;
                    state_next = ST_VAR_INIT;
                end else begin
                    m2_next    = alu_y[rmvs_pkg::ALU_W-1:0];
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                alu_req.a  = rmvs_pkg::ALU_W'(total_reg);
                alu_req.b  = rmvs_pkg::ALU_W'(x_reg);
                total_next = alu_y[rmvs_pkg::TOTAL_W-1:0];
                mean_next  = nmean_reg;
                count_next = n_reg;
                if (n_reg == COUNT_ONE) begin
                    min_next = x_reg;
                    max_next = x_reg;
                end else begin
                    if (x_reg < min_reg) begin
                        min_next = x_reg;
                    end
                    if (x_reg > max_reg) begin
                        max_next = x_reg;
                    end
                end
                state_next = ST_VAR_INIT;
            end
            ST_VAR_INIT: begin
                if (count_reg < COUNT_VAR_MIN) begin
                    var_next   = '0;
                    root_next  = '0;
                    state_next = ST_DONE;
                end else begin
                    acc_next   = m2_reg;
                    rem_next   = '0;
                    iter_next  = VAR_ITERS;
                    state_next = ST_VAR_DIV;
                end
            end
            ST_SQRT_INIT: begin
                var_next   = acc_reg;
                root_next  = '0;
                bit_next   = SQRT_BIT0;
                iter_next  = SQRT_ITERS;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                // The trial bit never overlaps the partial root, so OR stands for the add.
                alu_req.a   = acc_reg;
                alu_req.b   = root_reg | bit_reg;
                alu_req.sub = 1'b1;
                if (alu_carry) begin
                    acc_next  = alu_y[rmvs_pkg::ALU_W-1:0];
                    root_next = (root_reg >> 1) | bit_reg;
                end else begin
                    root_next = root_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                iter_next = iter_reg - ITER_LAST;
                if (iter_reg == ITER_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            mean_reg  <= '0;
            m2_reg    <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            total_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            mean_reg  <= mean_next;
            m2_reg    <= m2_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        ovf_reg   <= ovf_next;
        neg_reg   <= neg_next;
        n_reg     <= n_next;
        dmag_reg  <= dmag_next;
        nmean_reg <= nmean_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        prod_reg  <= prod_next;
        var_reg   <= var_next;
        root_reg  <= root_next;
        bit_reg   <= bit_next;
        iter_reg  <= iter_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb begin
        res.sample_count = count_reg;
        res.mean_q16     = mean_reg;
        res.min_us       = min_reg;
        res.max_us       = max_reg;
        res.total_us     = total_reg;
        res.overflow     = ovf_reg;
        if (var_reg[rmvs_pkg::ALU_W-1:rmvs_pkg::VAR_W] != '0) begin
            res.variance_q8 = {rmvs_pkg::VAR_W{1'b1}};
        end else begin
            res.variance_q8 = var_reg[rmvs_pkg::VAR_W-1:0];
        end
        if (root_reg[rmvs_pkg::ALU_W-1:rmvs_pkg::SD_W] != '0) begin
            res.std_dev_q4 = {rmvs_pkg::SD_W{1'b1}};
        end else begin
            res.std_dev_q4 = root_reg[rmvs_pkg::SD_W-1:0];
        end
    end

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP_DIV || state_reg == ST_VAR_DIV) |-> (rem_reg < den))
        else $error("division remainder reached the divisor");

    a_step_within_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MEAN) |-> (acc_reg[rmvs_pkg::MEAN_W-1:0] <= dmag_reg))
        else $error("mean step larger than the sample difference");

    a_commit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMMIT) |=> (min_reg <= max_reg && count_reg != '0))
        else $error("committed sample left min above max or an empty count");

    a_sqrt_bit_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQRT) |-> $onehot(bit_reg))
        else $error("square root trial bit is not one-hot");

    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && start && req.clear) |=>
        (count_reg == '0 && m2_reg == '0 && total_reg == '0))
        else $error("clear request left statistics behind");

endmodule

// ----- rtl/running_mean_variance_stats.sv -----
// Each request is worked serially on the one shared 64-bit adder: an added sample runs the
// mean divide, multiply and M2 add, and the variance divide and square root follow once the
// count is at least two; a clear and a rejected full-count sample skip the mean and M2 steps.
// Requests are taken one at a time; s_tready returns in the cycle after the result moves to
// the output register, which may still be waiting on m_tready.
// Reset: synchronous active-low aresetn zeroes every statistic and empties the output register.
module running_mean_variance_stats (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sample_us [23:0]
    input  logic [rmvs_pkg::S_TDATA_W-1:0]     s_tdata,
    // req_type [0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // sample_count [15:0], mean_q16 [55:16], variance_q8 [109:56], std_dev_q4 [136:110],
    // min_us [160:137], max_us [184:161], total_us [224:185], overflow [225], zeros above
    output logic [rmvs_pkg::M_TDATA_W-1:0]     m_tdata
);

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [rmvs_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    rmvs_pkg::stats_req_t    req;
    rmvs_pkg::stats_result_t res;
    logic                    eng_ready;
    logic                    res_valid;
    logic                    res_take;

    assign req.clear  = s_tuser;
    assign req.sample = s_tdata[rmvs_pkg::SAMPLE_BITS-1:0];
    assign s_tready   = eng_ready;

    rmvs_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_tvalid),
        .req       (req),
        .in_ready  (eng_ready),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // The engine hands over its result as soon as the output register is free.
    assign res_take = res_valid && (!m_tvalid_reg || m_tready);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_take) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = rmvs_pkg::M_TDATA_W'(res);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- dv/tb_running_mean_variance_stats.sv -----
`timescale 1ns / 100ps

module tb_running_mean_variance_stats;

    localparam int RUN_LIMIT      = 4_000_000;
    localparam int RX_HOLD_CYCLES = 2500;
    localparam int SETTLE_CYCLES  = 400;
    localparam int MAX_REPORTS    = 40;
    localparam int MIXED_ITEMS    = 280;
    localparam int SPREAD_ITEMS   = 1100;

    localparam logic [rmvs_pkg::SAMPLE_BITS-1:0] SMP_MAX = {rmvs_pkg::SAMPLE_BITS{1'b1}};

    typedef struct {
        logic                             clr;
        logic [rmvs_pkg::SAMPLE_BITS-1:0] smp;
        logic                             typed;
        rmvs_pkg::stats_result_t          ex;
    } stats_item_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [rmvs_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [rmvs_pkg::M_TDATA_W-1:0] m_tdata;

    // Typed-in expectation that travels beside the item on the bus.
    logic                    tbl_typed;
    rmvs_pkg::stats_result_t tbl_exp;

    // Running statistics as the block should hold them.
    logic [rmvs_pkg::COUNT_BITS-1:0]  acc_count = '0;
    logic [rmvs_pkg::MEAN_W-1:0]      acc_mean  = '0;
    logic [rmvs_pkg::M2_W-1:0]        acc_m2    = '0;
    logic [rmvs_pkg::SAMPLE_BITS-1:0] acc_min   = '0;
    logic [rmvs_pkg::SAMPLE_BITS-1:0] acc_max   = '0;
    logic [rmvs_pkg::TOTAL_W-1:0]     acc_total = '0;

    rmvs_pkg::stats_result_t expected_stats[$];
    stats_item_t             stim_rows[$];
    int                      mismatch_count = 0;
    int                      cycle_count    = 0;
    int                      burst_left     = 0;
    logic                    rx_hold_req    = 1'b0;

    running_mean_variance_stats dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [rmvs_pkg::M2_W-1:0] int_sqrt(
        input logic [rmvs_pkg::M2_W-1:0] v);
        logic [rmvs_pkg::M2_W-1:0] res, bitv, rem;
        res  = '0;
        rem  = v;
        bitv = 64'h1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Applies one request to the running statistics and returns the result it should produce.
    function automatic rmvs_pkg::stats_result_t welford_update(
        input logic clr, input logic [rmvs_pkg::SAMPLE_BITS-1:0] x);
        logic [rmvs_pkg::MEAN_W-1:0] xq, dmag, step, new_mean, d2mag, n;
        logic [rmvs_pkg::PROD_W-1:0] prod, term;
        logic [rmvs_pkg::M2_W:0]     m2_sum;
        logic [rmvs_pkg::M2_W-1:0]   var_full, sd_full;
        logic                        neg;
        rmvs_pkg::stats_result_t     r;
        r = '0;
        if (clr) begin
            acc_count = '0;
            acc_mean  = '0;
            acc_m2    = '0;
            acc_min   = '0;
            acc_max   = '0;
            acc_total = '0;
        end else if (acc_count == {rmvs_pkg::COUNT_BITS{1'b1}}) begin
            r.overflow = 1'b1;
        end else begin
            n        = rmvs_pkg::MEAN_W'(acc_count) + 1'b1;
            xq       = rmvs_pkg::MEAN_W'(x) << rmvs_pkg::MEAN_FRAC_BITS;
            neg      = xq < acc_mean;
            dmag     = neg ? acc_mean - xq : xq - acc_mean;
            step     = dmag / n;
            new_mean = neg ? acc_mean - step : acc_mean + step;
            d2mag    = neg ? new_mean - xq : xq - new_mean;
            prod     = rmvs_pkg::PROD_W'(dmag) * rmvs_pkg::PROD_W'(d2mag);
            term     = prod >> rmvs_pkg::M2_SHIFT;
            m2_sum   = {1'b0, acc_m2} + {1'b0, term[rmvs_pkg::M2_W-1:0]};
            // A sample that would push M2 past 64 bits leaves the state untouched.
            if ((term >> rmvs_pkg::M2_W) != 0 || m2_sum[rmvs_pkg::M2_W]) begin
                r.overflow = 1'b1;
            end else begin
                acc_m2    = m2_sum[rmvs_pkg::M2_W-1:0];
                acc_mean  = new_mean;
                acc_count = rmvs_pkg::COUNT_BITS'(n);
                acc_total = acc_total + rmvs_pkg::TOTAL_W'(x);
                if (n == 1) begin
                    acc_min = x;
                    acc_max = x;
                end else begin
                    if (x < acc_min)
                        acc_min = x;
                    if (x > acc_max)
                        acc_max = x;
                end
            end
        end
        var_full = (acc_count >= rmvs_pkg::VAR_MIN_COUNT)
                   ? acc_m2 / rmvs_pkg::M2_W'(acc_count) : '0;
        sd_full  = int_sqrt(var_full);
        r.sample_count = acc_count;
        r.mean_q16     = acc_mean;
        r.variance_q8  = ((var_full >> rmvs_pkg::VAR_W) != 0) ? {rmvs_pkg::VAR_W{1'b1}}
                                                              : var_full[rmvs_pkg::VAR_W-1:0];
        r.std_dev_q4   = ((sd_full >> rmvs_pkg::SD_W) != 0) ? {rmvs_pkg::SD_W{1'b1}}
                                                            : sd_full[rmvs_pkg::SD_W-1:0];
        r.min_us       = acc_min;
        r.max_us       = acc_max;
        r.total_us     = acc_total;
        return r;
    endfunction

    function automatic stats_item_t mk_item(input logic clr,
                                            input logic [rmvs_pkg::SAMPLE_BITS-1:0] smp,
                                            input logic typed,
                                            input rmvs_pkg::stats_result_t ex);
        stats_item_t it;
        it.clr   = clr;
        it.smp   = smp;
        it.typed = typed;
        it.ex    = ex;
        return it;
    endfunction

    task automatic add_row(input logic clr, input logic [rmvs_pkg::SAMPLE_BITS-1:0] smp,
                           input logic typed, input rmvs_pkg::stats_result_t ex);
        stim_rows = {stim_rows, mk_item(clr, smp, typed, ex)};
    endtask

    function automatic logic [rmvs_pkg::SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SMP_MAX;
            2:       return rmvs_pkg::SAMPLE_BITS'($urandom_range(0, 255));
            3:       return rmvs_pkg::SAMPLE_BITS'($urandom_range(1000, 1100));
            4:       return SMP_MAX - rmvs_pkg::SAMPLE_BITS'($urandom_range(0, 255));
            default: return rmvs_pkg::SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            if (mismatch_count < MAX_REPORTS)
                $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    // Sender side: holds the item until accepted, then maybe idles before the next burst.
    task automatic send_item(input stats_item_t it);
        int unsigned gap;
        s_tvalid  <= 1'b1;
        s_tuser   <= it.clr;
        s_tdata   <= rmvs_pkg::S_TDATA_W'(it.smp);
        tbl_typed <= it.typed;
        tbl_exp   <= it.ex;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 15);
            case ($urandom_range(0, 4))
                0, 1:    gap = 0;
                2, 3:    gap = $urandom_range(1, 24);
                default: gap = $urandom_range(25, 300);
            endcase
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    always @(posedge aclk) begin : scoreboard
        rmvs_pkg::stats_result_t got, want, pred;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = rmvs_pkg::stats_result_t'(m_tdata[rmvs_pkg::RES_BITS-1:0]);
                if (expected_stats.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("%0t: result with nothing expected, expected none got %0h",
                                 $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_stats.pop_front();
                    check_field("sample_count", 64'(want.sample_count), 64'(got.sample_count));
                    check_field("mean_q16", 64'(want.mean_q16), 64'(got.mean_q16));
                    check_field("variance_q8", 64'(want.variance_q8), 64'(got.variance_q8));
                    check_field("std_dev_q4", 64'(want.std_dev_q4), 64'(got.std_dev_q4));
                    check_field("min_us", 64'(want.min_us), 64'(got.min_us));
                    check_field("max_us", 64'(want.max_us), 64'(got.max_us));
                    check_field("total_us", 64'(want.total_us), 64'(got.total_us));
                    check_field("overflow", 64'(want.overflow), 64'(got.overflow));
                    check_field("tdata padding", '0,
                                64'(m_tdata[rmvs_pkg::M_TDATA_W-1:rmvs_pkg::RES_BITS]));
                end
            end
            if (s_tvalid && s_tready) begin
                pred = welford_update(s_tuser, s_tdata[rmvs_pkg::SAMPLE_BITS-1:0]);
                expected_stats = {expected_stats, (tbl_typed ? tbl_exp : pred)};
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("FAIL running_mean_variance_stats");
            $finish;
        end
    end

    // Receiver side: changes its stall pattern after each random span, and on request
    // holds off long enough for the block to back up into its input.
    initial begin
        int unsigned rx_mode, rx_span;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end
            rx_mode = $urandom_range(0, 3);
            rx_span = $urandom_range(32, 600);
            for (int i = 0; i < rx_span && !rx_hold_req; i++) begin
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 9) < 7);
                    2:       m_tready <= ($urandom_range(0, 9) < 2);
                    default: m_tready <= (i % 5 == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    initial begin
        stats_item_t             it;
        rmvs_pkg::stats_result_t zero_res, one_zero_res, one_max_res;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        tbl_typed <= 1'b0;
        tbl_exp   <= '0;

        zero_res = '0;
        one_zero_res = '0;
        one_zero_res.sample_count = 1;
        one_max_res = '0;
        one_max_res.sample_count = 1;
        one_max_res.mean_q16     = rmvs_pkg::MEAN_W'(SMP_MAX) << rmvs_pkg::MEAN_FRAC_BITS;
        one_max_res.min_us       = SMP_MAX;
        one_max_res.max_us       = SMP_MAX;
        one_max_res.total_us     = rmvs_pkg::TOTAL_W'(SMP_MAX);

        add_row(1'b1, '0, 1'b1, zero_res);
        add_row(1'b0, '0, 1'b1, one_zero_res);
        add_row(1'b0, SMP_MAX, 1'b0, zero_res);
        add_row(1'b0, SMP_MAX, 1'b0, zero_res);
        add_row(1'b0, 24'h000001, 1'b0, zero_res);
        add_row(1'b0, 24'h800000, 1'b0, zero_res);
        // The sample field is ignored on a clear, even when all its bits are set.
        add_row(1'b1, SMP_MAX, 1'b1, zero_res);
        add_row(1'b0, SMP_MAX, 1'b1, one_max_res);
        add_row(1'b0, '0, 1'b0, zero_res);
        add_row(1'b0, 24'h555555, 1'b0, zero_res);
        add_row(1'b0, 24'hAAAAAA, 1'b0, zero_res);
        add_row(1'b0, 24'hFFFFFE, 1'b0, zero_res);
        add_row(1'b1, 24'h123456, 1'b1, zero_res);
        add_row(1'b0, 24'h000007, 1'b0, zero_res);
        add_row(1'b0, 24'h000007, 1'b0, zero_res);
        add_row(1'b0, 24'h000007, 1'b0, zero_res);
        add_row(1'b0, 24'h000008, 1'b0, zero_res);
        add_row(1'b1, '0, 1'b1, zero_res);
        add_row(1'b0, 24'h000001, 1'b0, zero_res);
        add_row(1'b0, 24'h000002, 1'b0, zero_res);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[i])
            send_item(stim_rows[i]);

        // Mixed traffic: mostly samples, with a clear now and then to restart the statistics.
        for (int i = 0; i < MIXED_ITEMS; i++) begin
            if (i == 60)
                rx_hold_req = 1'b1;
            if (i == 150) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (expected_stats.size() != 0)
                    @(posedge aclk);
                @(posedge aclk);
            end
            if ($urandom_range(0, 24) == 0)
                it = mk_item(1'b1, rmvs_pkg::SAMPLE_BITS'($urandom), 1'b0, zero_res);
            else
                it = mk_item(1'b0, pick_sample(), 1'b0, zero_res);
            send_item(it);
        end

        // Samples swinging between the range ends grow M2 by about 2^54 each, so after
        // roughly a thousand of them the sum no longer fits and samples get rejected.
        send_item(mk_item(1'b1, rmvs_pkg::SAMPLE_BITS'($urandom), 1'b0, zero_res));
        for (int i = 0; i < SPREAD_ITEMS; i++) begin
            if (i == 500)
                rx_hold_req = 1'b1;
            if ($urandom_range(0, 15) == 0)
                it = mk_item(1'b0, rmvs_pkg::SAMPLE_BITS'($urandom), 1'b0, zero_res);
            else if (i % 2 == 0)
                it = mk_item(1'b0, rmvs_pkg::SAMPLE_BITS'($urandom_range(0, 63)), 1'b0,
                             zero_res);
            else
                it = mk_item(1'b0, SMP_MAX - rmvs_pkg::SAMPLE_BITS'($urandom_range(0, 63)),
                             1'b0, zero_res);
            send_item(it);
        end

        send_item(mk_item(1'b1, '0, 1'b0, zero_res));
        for (int i = 0; i < 5; i++)
            send_item(mk_item(1'b0, pick_sample(), 1'b0, zero_res));

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_stats.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("PASS running_mean_variance_stats");
        else
            $display("FAIL running_mean_variance_stats");
        $finish;
    end

endmodule
